// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define CVOQ_ASSERT_IMPL(lbl, clk, dis, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define CVOQ_ASSERT_NEXT(lbl, clk, dis, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- hw/rtl/cvoq_pkg.sv -----
`timescale 1ns / 1ps

package cvoq_pkg;

  // Field widths of the channels and registers.
  localparam int VOLT_W  = 24;
  localparam int KNOB_W  = 17;
  localparam int SCALE_W = 25;
  localparam int BASE_W  = 24;
  localparam int MODE_W  = 3;
  localparam int IVL_W   = 23;
  localparam int SIDE_W  = VOLT_W + 1;

  // Register port geometry.
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_RANGE_SCALE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_BASE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUANT_MODE     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_QUANT_INTERVAL = 2'd3;

  // Register reset values.
  localparam logic signed [SCALE_W-1:0] RST_RANGE_SCALE    = 25'sd1310720;
  localparam logic signed [BASE_W-1:0]  RST_RANGE_BASE     = -24'sd655360;
  localparam logic [MODE_W-1:0]         RST_QUANT_MODE     = 3'd0;
  localparam logic [IVL_W-1:0]          RST_QUANT_INTERVAL = 23'd65536;

  // Quantizer mode codes.
  localparam logic [MODE_W-1:0] QM_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] QM_OUT_INT  = 3'd1;
  localparam logic [MODE_W-1:0] QM_OUT_SEMI = 3'd2;
  localparam logic [MODE_W-1:0] QM_OUT_CUST = 3'd3;
  localparam logic [MODE_W-1:0] QM_OFF_INT  = 3'd4;
  localparam logic [MODE_W-1:0] QM_OFF_SEMI = 3'd5;
  localparam logic [MODE_W-1:0] QM_OFF_CUST = 3'd6;

  // Quantizer step kinds.
  localparam logic [1:0] QK_NONE = 2'd0;
  localparam logic [1:0] QK_INT  = 2'd1;
  localparam logic [1:0] QK_SEMI = 2'd2;
  localparam logic [1:0] QK_CUST = 2'd3;

  // Output rails.
  localparam logic signed [VOLT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [VOLT_W-1:0] OUT_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [VOLT_W-1:0] in_voltage;
    logic [KNOB_W-1:0]        knob_position;
  } sample_t;

  typedef struct packed {
    logic signed [VOLT_W-1:0] out_voltage;
    logic                     clipped;
  } result_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] range_scale;
    logic signed [BASE_W-1:0]  range_base;
    logic [MODE_W-1:0]         quant_mode;
    logic [IVL_W-1:0]          quant_interval;
  } cfg_t;

  // Step kind selected by a mode; the unused code means no quantization.
  function automatic logic [1:0] quant_kind(input logic [MODE_W-1:0] mode);
    logic [1:0] kind;
    case (mode) inside
      QM_OUT_INT, QM_OFF_INT:   kind = QK_INT;
      QM_OUT_SEMI, QM_OFF_SEMI: kind = QK_SEMI;
      QM_OUT_CUST, QM_OFF_CUST: kind = QK_CUST;
      default:                  kind = QK_NONE;
    endcase
    return kind;
  endfunction

  // True when the offset is quantized before the add.
  function automatic logic offset_mode(input logic [MODE_W-1:0] mode);
    logic hit;
    case (mode) inside
      QM_OFF_INT, QM_OFF_SEMI, QM_OFF_CUST: hit = 1'b1;
      default:                              hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ----- hw/rtl/cvoq_stream_if.sv -----
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload beat per handshake.
interface cvoq_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cvoq_cfg.sv -----
`timescale 1ns / 1ps

module cvoq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvoq_pkg::ADDR_W-1:0]   paddr,
  input  logic [cvoq_pkg::DATA_W-1:0]   pwdata,
  output logic [cvoq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cvoq_pkg::cfg_t                cfg
);
  import cvoq_pkg::*;

  cfg_t                 regs;
  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg    = regs;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.range_scale    <= RST_RANGE_SCALE;
      regs.range_base     <= RST_RANGE_BASE;
      regs.quant_mode     <= RST_QUANT_MODE;
      regs.quant_interval <= RST_QUANT_INTERVAL;
    end else if (wr) begin
      unique case (idx)
        REG_RANGE_SCALE:    regs.range_scale    <= pwdata[SCALE_W-1:0];
        REG_RANGE_BASE:     regs.range_base     <= pwdata[BASE_W-1:0];
        REG_QUANT_MODE:     regs.quant_mode     <= pwdata[MODE_W-1:0];
        REG_QUANT_INTERVAL: regs.quant_interval <= pwdata[IVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the raw register bits.
  always_comb begin
    unique case (idx)
      REG_RANGE_SCALE:    prdata = {{(DATA_W-SCALE_W){1'b0}}, regs.range_scale};
      REG_RANGE_BASE:     prdata = {{(DATA_W-BASE_W){1'b0}}, regs.range_base};
      REG_QUANT_MODE:     prdata = {{(DATA_W-MODE_W){1'b0}}, regs.quant_mode};
      REG_QUANT_INTERVAL: prdata = {{(DATA_W-IVL_W){1'b0}}, regs.quant_interval};
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/cvoq_prep.sv -----
`timescale 1ns / 1ps

module cvoq_prep #(
  parameter int FRAC_BITS = 16,
  parameter int PROD_W    = 43,
  parameter int SMAG_W    = 28,
  parameter int OFF_W     = 30,
  parameter int X_W       = 31,
  parameter int NMAG_W    = 35,
  parameter int D_W       = 23,
  parameter int DVD_W     = 36
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cvoq_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cvoq_pkg::sample_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DVD_W-1:0]              out_dvd,
  output logic [cvoq_pkg::SIDE_W-1:0]   out_side,
  output logic [D_W-1:0]                divisor
);
  import cvoq_pkg::*;

  localparam int NS = 7;
  localparam logic [PROD_W-1:0] HALF_P   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [NMAG_W-1:0] HALF_N   = NMAG_W'(1) << (FRAC_BITS - 1);
  localparam logic [NMAG_W-1:0] LOW_MASK = (NMAG_W'(1) << FRAC_BITS) - NMAG_W'(1);
  localparam logic [D_W-1:0]    ONE_D    = D_W'(1) << FRAC_BITS;

  logic [NS:1]   v;
  logic [NS+1:1] en;
  logic [1:0]    kind;
  logic          off_q;

  logic signed [PROD_W-1:0] prod1;
  logic signed [VOLT_W-1:0] vin1, vin2, vin3, vin4, vin5, vin6, vin7;
  logic [SMAG_W-1:0]        smag2;
  logic                     psign2;
  logic signed [OFF_W-1:0]  off3;
  logic signed [X_W-1:0]    x4;
  logic [NMAG_W-1:0]        xmag5, n6;
  logic                     xneg5, xneg6, xneg7;
  logic [DVD_W-1:0]         dvd7;

  logic [PROD_W-1:0]        pmag, prnd;
  logic signed [OFF_W-1:0]  soff;
  logic [NMAG_W-1:0]        m12;

  assign kind  = quant_kind(cfg.quant_mode);
  assign off_q = offset_mode(cfg.quant_mode);

  // Divisor of the rounding divide for the selected step kind.
  always_comb begin
    case (kind)
      QK_INT:  divisor = ONE_D;
      QK_SEMI: divisor = D_W'(12);
      QK_CUST: divisor = (cfg.quant_interval == '0) ? ONE_D : D_W'(cfg.quant_interval);
      default: divisor = D_W'(1);
    endcase
  end

  // Elastic stage enables: a stage loads when empty or when it drains.
  assign en[NS+1] = out_ready;
  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: knob times span.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1 <= $signed({1'b0, in_data.knob_position}) * cfg.range_scale;
      vin1  <= in_data.in_voltage;
    end
  end

  // Stage 2: round the scaled product half away from zero.
  assign pmag = prod1[PROD_W-1] ? PROD_W'(-prod1) : PROD_W'(prod1);
  assign prnd = pmag + HALF_P;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      smag2  <= SMAG_W'(prnd >> FRAC_BITS);
      psign2 <= prod1[PROD_W-1];
      vin2   <= vin1;
    end
  end

  // Stage 3: restore sign and add the base.
  assign soff = $signed(OFF_W'(smag2));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      off3 <= (psign2 ? -soff : soff) + OFF_W'($signed(cfg.range_base));
      vin3 <= vin2;
    end
  end

  // Stage 4: pick the value that goes through the quantizer.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      x4   <= off_q ? X_W'(off3) : X_W'(off3) + X_W'(vin3);
      vin4 <= vin3;
    end
  end

  // Stage 5: split into sign and magnitude.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      xmag5 <= x4[X_W-1] ? NMAG_W'(-x4) : NMAG_W'(x4);
      xneg5 <= x4[X_W-1];
      vin5  <= vin4;
    end
  end

  // Stage 6: semitones first snap twelve times the value to whole volts.
  assign m12 = (xmag5 << 3) + (xmag5 << 2) + HALF_N;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      n6    <= (kind == QK_SEMI) ? (m12 & ~LOW_MASK) : xmag5;
      xneg6 <= xneg5;
      vin6  <= vin5;
    end
  end

  // Stage 7: add half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      dvd7  <= DVD_W'(n6) + DVD_W'(divisor >> 1);
      xneg7 <= xneg6;
      vin7  <= vin6;
    end
  end

  assign out_valid = v[NS];
  assign out_dvd   = dvd7;
  assign out_side  = {xneg7, vin7};

endmodule

// ----- hw/rtl/cvoq_div.sv -----
`timescale 1ns / 1ps

module cvoq_div #(
  parameter int DVD_W  = 36,
  parameter int D_W    = 23,
  parameter int SIDE_W = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [D_W-1:0]    divisor,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DVD_W-1:0]  in_dvd,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DVD_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  // One restoring step per stage, most significant quotient bit first.
  logic [D_W-1:0]    rem  [DVD_W];
  logic [DVD_W-1:0]  acc  [DVD_W];
  logic [SIDE_W-1:0] side [DVD_W];
  logic [DVD_W-1:0]  v;
  logic [DVD_W:0]    en;

  assign en[DVD_W] = out_ready;
  assign in_ready  = en[0];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [D_W-1:0]    rem_in;
    logic [DVD_W-1:0]  acc_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in;
    logic [D_W:0]      trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign acc_in  = in_dvd;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign acc_in  = acc[k-1];
      assign side_in = side[k-1];
      assign v_in    = v[k-1];
    end

    assign en[k] = !v[k] || en[k+1];
    assign trial = {rem_in, acc_in[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        acc[k]  <= {acc_in[DVD_W-2:0], ge};
        side[k] <= side_in;
      end
    end
  end

  assign out_valid = v[DVD_W-1];
  assign out_quo   = acc[DVD_W-1];
  assign out_side  = side[DVD_W-1];

endmodule

// ----- hw/rtl/cvoq_post.sv -----
`timescale 1ns / 1ps

module cvoq_post #(
  parameter int FRAC_BITS = 16,
  parameter int DVD_W     = 36,
  parameter int X_W       = 31,
  parameter int D_W       = 23,
  parameter int RMAG_W    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cvoq_pkg::cfg_t                cfg,
  input  logic [D_W-1:0]                divisor,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [DVD_W-1:0]              in_quo,
  input  logic [cvoq_pkg::SIDE_W-1:0]   in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cvoq_pkg::result_t             out_data
);
  import cvoq_pkg::*;

  localparam int NS    = 4;
  localparam int LO_W  = 16;
  localparam int HI_W  = X_W - LO_W;
  localparam int PF_W  = X_W + D_W;
  localparam int SUM_W = RMAG_W + 2;

  logic [NS:1]   v;
  logic [NS+1:1] en;
  logic [1:0]    kind;
  logic          off_q;

  logic [LO_W+D_W-1:0]      plo1;
  logic [HI_W+D_W-1:0]      phi1;
  logic [RMAG_W-1:0]        q1, rmag2;
  logic [SIDE_W-1:0]        side1, side2;
  logic signed [SUM_W-1:0]  sum3;
  result_t                  res4;

  logic [PF_W-1:0]          pfull;
  logic [RMAG_W-1:0]        rmag;
  logic signed [SUM_W-1:0]  vt, rs;

  assign kind  = quant_kind(cfg.quant_mode);
  assign off_q = offset_mode(cfg.quant_mode);

  // Elastic stage enables; the last stage is the output register.
  assign en[NS+1] = out_ready;
  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: quotient times interval as two partial products.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      plo1  <= in_quo[LO_W-1:0] * divisor;
      phi1  <= in_quo[X_W-1:LO_W] * divisor;
      q1    <= in_quo[RMAG_W-1:0];
      side1 <= in_side;
    end
  end

  // Stage 2: scale the quotient back to volts.
  assign pfull = (PF_W'(phi1) << LO_W) + PF_W'(plo1);

  always_comb begin
    case (kind)
      QK_CUST: rmag = RMAG_W'(pfull);
      QK_INT:  rmag = q1 << FRAC_BITS;
      default: rmag = q1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rmag2 <= rmag;
      side2 <= side1;
    end
  end

  // Stage 3: apply the sign and add the input after offset quantization.
  assign vt = off_q ? SUM_W'($signed(side2[VOLT_W-1:0])) : '0;
  assign rs = $signed(SUM_W'(rmag2));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sum3 <= side2[SIDE_W-1] ? vt - rs : vt + rs;
    end
  end

  // Stage 4: saturate into the output register.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (sum3 > SUM_W'(OUT_MAX)) begin
        res4.out_voltage <= OUT_MAX;
        res4.clipped     <= 1'b1;
      end else if (sum3 < SUM_W'(OUT_MIN)) begin
        res4.out_voltage <= OUT_MIN;
        res4.clipped     <= 1'b1;
      end else begin
        res4.out_voltage <= sum3[VOLT_W-1:0];
        res4.clipped     <= 1'b0;
      end
    end
  end

  assign out_valid = v[NS];
  assign out_data  = res4;

endmodule

// ----- hw/rtl/cv_offset_quantizer_core.sv -----
// Offset and pitch quantizer for one control-voltage channel.
// The sample channel takes one beat per item: in_voltage and knob_position.
// The result channel returns one beat per item: out_voltage and clipped.
// Both channels use valid/ready; a beat moves when both are high.
// The APB port holds range_scale, range_base, quant_mode and quant_interval
// at byte addresses 0, 4, 8 and 12; write it only while no item is in flight.
// Throughput is one item per cycle while the result channel is not stalled.
// A beat passes seven front stages, one divider stage per quotient bit
// (DVD_W of them), and four back stages.
// Every stage is elastic: when the receiver stalls, beats pile up behind the
// output register, bubbles are filled, and ready drops only once every stage
// holds a beat. Nothing is dropped or repeated.
// Reset empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cv_offset_quantizer_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  cvoq_stream_if.sink                   sample,
  cvoq_stream_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvoq_pkg::ADDR_W-1:0]   paddr,
  input  logic [cvoq_pkg::DATA_W-1:0]   pwdata,
  output logic [cvoq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import cvoq_pkg::*;

  // Datapath widths follow from the fraction width.
  localparam int PROD_W = KNOB_W + 1 + SCALE_W;
  localparam int SMAG_W = PROD_W - FRAC_BITS + 1;
  localparam int OFF_W  = ((SMAG_W + 1 > BASE_W) ? SMAG_W + 1 : BASE_W) + 1;
  localparam int X_W    = ((OFF_W > VOLT_W) ? OFF_W : VOLT_W) + 1;
  localparam int NMAG_W = X_W + 4;
  localparam int D_W    = (IVL_W > FRAC_BITS + 1) ? IVL_W : FRAC_BITS + 1;
  localparam int DVD_W  = ((NMAG_W > D_W) ? NMAG_W : D_W) + 1;
  localparam int RMAG_W = X_W + 1;

  cfg_t              cfg;
  logic [D_W-1:0]    divisor;
  logic              p_valid, p_ready;
  logic [DVD_W-1:0]  p_dvd;
  logic [SIDE_W-1:0] p_side;
  logic              d_valid, d_ready;
  logic [DVD_W-1:0]  d_quo;
  logic [SIDE_W-1:0] d_side;
  result_t           r_data;

  cvoq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cvoq_prep #(
    .FRAC_BITS (FRAC_BITS),
    .PROD_W    (PROD_W),
    .SMAG_W    (SMAG_W),
    .OFF_W     (OFF_W),
    .X_W       (X_W),
    .NMAG_W    (NMAG_W),
    .D_W       (D_W),
    .DVD_W     (DVD_W)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_data   (sample.data),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_dvd   (p_dvd),
    .out_side  (p_side),
    .divisor   (divisor)
  );

  cvoq_div #(
    .DVD_W  (DVD_W),
    .D_W    (D_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (divisor),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_dvd    (p_dvd),
    .in_side   (p_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  cvoq_post #(
    .FRAC_BITS (FRAC_BITS),
    .DVD_W     (DVD_W),
    .X_W       (X_W),
    .D_W       (D_W),
    .RMAG_W    (RMAG_W)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .divisor   (divisor),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_quo    (d_quo),
    .in_side   (d_side),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (r_data)
  );

  assign result.data = r_data;

  // A clipped beat always sits on one of the rails.
  `CVOQ_ASSERT_IMPL(a_clip_rail, clk, rst, result.valid && result.data.clipped, result.data.out_voltage == OUT_MAX || result.data.out_voltage == OUT_MIN, "clipped beat not at a rail")

  // Input back-pressure only when the output itself is stalled.
  `CVOQ_ASSERT_IMPL(a_full_only, clk, rst, !sample.ready, result.valid && !result.ready, "sample stalled without output stall")

  // Reset empties the pipeline.
  `CVOQ_ASSERT_NEXT(a_reset_flush, clk, 1'b0, rst, !result.valid, "result valid after reset")

endmodule
